// File: sv/edge_circulation_and_flux_defines.svh
// Assertion macros shared by the edge circulation and flux RTL.
// Expects clk and rst to be visible where a macro is used.
`ifndef EDGE_CIRCULATION_AND_FLUX_DEFINES_SVH
`define EDGE_CIRCULATION_AND_FLUX_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define ECF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define ECF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ecf_pkg.sv
// Types and constants for the edge circulation and flux pipeline.
// No dependencies; imported by every design and bench module.
package ecf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HSTEPS    = 6;

  localparam logic [7:0]  HORNER_DIV [HSTEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [26:0] DEG2RAD     = 27'd74961321;
  localparam logic [24:0] ANG_FULL    = 25'(360 << FRAC_BITS);
  localparam logic [24:0] ANG_HALF    = 25'(180 << FRAC_BITS);
  localparam logic [24:0] ANG_QUARTER = 25'(90 << FRAC_BITS);

  typedef struct packed {
    logic signed [26:0] dx;
    logic signed [24:0] dy;
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic               edge_neg;
    logic               flux_neg;
    logic               mode;
    logic               cos_neg;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] y;
    logic [30:0] t;
  } lane_t;

  typedef struct packed {
    logic signed [47:0] edge_integral;
    logic signed [47:0] face_flux;
  } res_t;

endpackage

// File: sv/ecf_channels.sv
// Valid/ready channel interfaces: edge items, results and configuration.
// Depends on nothing.
interface ecf_item_if;
  logic               valid;
  logic               ready;
  logic signed [25:0] lon_start;
  logic signed [23:0] lat_start;
  logic signed [25:0] lon_end;
  logic signed [23:0] lat_end;
  logic signed [31:0] east_component;
  logic signed [31:0] north_component;
  logic [1:0]         edge_position;
  logic               orientation_negative;

  modport source (output valid, lon_start, lat_start, lon_end, lat_end, east_component,
                  north_component, edge_position, orientation_negative, input ready);
  modport sink (input valid, lon_start, lat_start, lon_end, lat_end, east_component,
                north_component, edge_position, orientation_negative, output ready);
endinterface

interface ecf_result_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] edge_integral;
  logic signed [47:0] face_flux;

  modport source (output valid, edge_integral, face_flux, input ready);
  modport sink (input valid, edge_integral, face_flux, output ready);
endinterface

interface ecf_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: sv/ecf_horner_step.sv
// One Horner step of the cosine series: t = 1 - (y*t)/div, three stages.
// Depends on ecf_pkg.
module ecf_horner_step import ecf_pkg::*; #(
  parameter logic [7:0] DIV = 8'd2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  vld_i,
  input  lane_t lane_i,
  output logic  vld_o,
  output lane_t lane_o
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);

  logic        a_vld, b_vld;
  logic [31:0] a_q, b_q, b_est;
  lane_t       a_lane, b_lane;
  logic [61:0] prod_a;
  logic [63:0] prod_b;
  logic [31:0] rem, quo;
  logic [30:0] t_next;
  lane_t       lane_n;

  assign prod_a = 62'(lane_i.y) * 62'(lane_i.t);
  assign prod_b = 64'(a_q) * 64'(RECIP);

  always_comb begin
    rem      = b_q - 32'(b_est * 32'(DIV));
    quo      = b_est + 32'(rem >= 32'(DIV));
    t_next   = (quo > 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - quo);
    lane_n   = b_lane;
    lane_n.t = t_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      vld_o <= 1'b0;
    end else if (en) begin
      a_vld <= vld_i;
      b_vld <= a_vld;
      vld_o <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_q         <= prod_a[30 +: 32];
      a_lane      <= lane_i;
      b_est       <= prod_b[63:32];
      b_q         <= a_q;
      b_lane      <= a_lane;
      lane_o      <= lane_n;
    end
  end

endmodule

// File: sv/ecf_cosine.sv
// Cosine of the mean latitude: angle fold, radians, square, Horner chain.
// Depends on ecf_pkg and ecf_horner_step.
module ecf_cosine import ecf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vld_i,
  input  side_t       side_i,
  input  logic [23:0] ang_i,
  output logic        vld_o,
  output lane_t       lane_o
);

  logic        c1_vld, c2_vld, c3_vld;
  side_t       c1_side, c2_side;
  logic [22:0] c1_af;
  logic [30:0] c2_x;
  lane_t       c3_lane;
  logic [24:0] a1;
  logic [22:0] af;
  logic        fold_neg;
  side_t       side_f;
  logic [49:0] prod_x;
  logic [61:0] prod_y;
  logic        h_vld  [HSTEPS+1];
  lane_t       h_lane [HSTEPS+1];

  always_comb begin
    a1       = ({1'b0, ang_i} > ANG_HALF) ? ANG_FULL - {1'b0, ang_i} : {1'b0, ang_i};
    fold_neg = a1 > ANG_QUARTER;
    af       = fold_neg ? 23'(ANG_HALF - a1) : a1[22:0];
    side_f         = side_i;
    side_f.cos_neg = fold_neg;
  end

  assign prod_x = 50'(c1_af) * 50'(DEG2RAD);
  assign prod_y = 62'(c2_x) * 62'(c2_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_vld <= 1'b0;
      c2_vld <= 1'b0;
      c3_vld <= 1'b0;
    end else if (en) begin
      c1_vld <= vld_i;
      c2_vld <= c1_vld;
      c3_vld <= c2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_side         <= side_f;
      c1_af           <= af;
      c2_side         <= c1_side;
      c2_x            <= prod_x[FRAC_BITS+2 +: 31];
      c3_lane.side    <= c2_side;
      c3_lane.y       <= prod_y[30 +: 32];
      c3_lane.t       <= Q30_ONE;
    end
  end

  assign h_vld[0]  = c3_vld;
  assign h_lane[0] = c3_lane;

  for (genvar g = 0; g < HSTEPS; g++) begin : g_step
    ecf_horner_step #(.DIV(HORNER_DIV[g])) u_step (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vld_i  (h_vld[g]),
      .lane_i (h_lane[g]),
      .vld_o  (h_vld[g+1]),
      .lane_o (h_lane[g+1])
    );
  end

  assign vld_o  = h_vld[HSTEPS];
  assign lane_o = h_lane[HSTEPS];

endmodule

// File: sv/ecf_combine.sv
// Scaled longitude step, the four products, sums, rounding and signs.
// Depends on ecf_pkg.
module ecf_combine import ecf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  vld_i,
  input  lane_t lane_i,
  output logic  vld_o,
  output res_t  res_o
);

  logic               m1_vld, m2_vld, m3_vld, m4_vld;
  side_t              m1_side, m2_side, m3_side, m4_side;
  logic [56:0]        m1_mag;
  logic               m1_neg;
  logic signed [26:0] m2_cdx;
  logic signed [58:0] m3_ec, m3_nd, m3_ed, m3_nc;
  logic signed [59:0] m4_e, m4_f;
  logic               dx_neg;
  logic [25:0]        dx_mag;
  logic [26:0]        r_cdx;
  logic signed [26:0] cdx;

  // Magnitude stays below 2^58, so the 48-bit result never clips
  function automatic logic signed [47:0] round_out(input logic signed [59:0] s,
                                                   input logic flip);
    logic [59:0] mag;
    logic [43:0] r;
    logic [47:0] r48;
    mag = s[59] ? 60'(-s) : 60'(s);
    r   = 44'((mag + (60'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
    r48 = 48'(r);
    return $signed((s[59] ^ flip) ? -r48 : r48);
  endfunction

  always_comb begin
    dx_neg = lane_i.side.dx[26];
    dx_mag = dx_neg ? 26'(-lane_i.side.dx) : 26'(lane_i.side.dx);
    r_cdx  = 27'((m1_mag + (57'(1) << 29)) >> 30);
    if (m1_side.mode) begin
      cdx = m1_neg ? $signed(-r_cdx) : $signed(r_cdx);
    end else begin
      cdx = m1_side.dx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      m3_vld <= 1'b0;
      m4_vld <= 1'b0;
      vld_o  <= 1'b0;
    end else if (en) begin
      m1_vld <= vld_i;
      m2_vld <= m1_vld;
      m3_vld <= m2_vld;
      m4_vld <= m3_vld;
      vld_o  <= m4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_side <= lane_i.side;
      m1_mag  <= 57'(lane_i.t) * 57'(dx_mag);
      m1_neg  <= dx_neg ^ lane_i.side.cos_neg;
      m2_side <= m1_side;
      m2_cdx  <= cdx;
      m3_side <= m2_side;
      m3_ec   <= 59'(m2_side.u) * 59'(m2_cdx);
      m3_nd   <= 59'(m2_side.v) * 59'(m2_side.dy);
      m3_ed   <= 59'(m2_side.u) * 59'(m2_side.dy);
      m3_nc   <= 59'(m2_side.v) * 59'(m2_cdx);
      m4_side <= m3_side;
      m4_e    <= 60'(m3_ec) + 60'(m3_nd);
      m4_f    <= 60'(m3_ed) - 60'(m3_nc);
      res_o.edge_integral <= round_out(m4_e, m4_side.edge_neg);
      res_o.face_flux     <= round_out(m4_f, m4_side.flux_neg);
    end
  end

endmodule

// File: sv/ecf_skid.sv
// Output register with one skid entry; decouples pipeline advance from ready.
// Depends on ecf_pkg.
module ecf_skid import ecf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic vld_i,
  input  res_t data_i,
  input  logic out_ready,
  output logic en,
  output logic out_valid,
  output res_t out_data,
  output logic skid_full
);

  res_t skid_data;

  assign en = !skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ready) begin
        skid_full <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid <= vld_i;
    end else if (vld_i) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_ready) begin
        out_data <= skid_data;
      end
    end else if (!out_valid || out_ready) begin
      out_data <= data_i;
    end else begin
      skid_data <= data_i;
    end
  end

endmodule

// File: sv/edge_circulation_and_flux.sv
// Top level: edge circulation and face flux, fully pipelined.
// Depends on ecf_pkg, ecf_channels, ecf_cosine, ecf_combine, ecf_skid.
//
// Channels: edge_item takes one grid edge per transaction (endpoints,
// vector components, edge position, orientation); result returns the
// edge circulation and face flux, Q32.16 in 48 bits. cfg writes the
// angle_in_degrees bit; it is always ready and applies to items accepted
// after the write.
// Throughput: one transaction per cycle while not stalled, set by a register
// after every multiplier (cosine Horner chain and four products).
// Path: an accepted item passes one entry stage, 21 cosine stages, five
// combine stages and the output register before its result is valid.
// Reset: clears all valid bits and sets angle_in_degrees to 1.
// Stall: the output register plus one skid entry absorb a held-off result;
// edge_item.ready falls once the skid entry is taken and the whole pipeline
// holds until the receiver drains it. Nothing is dropped or repeated.
`include "edge_circulation_and_flux_defines.svh"

module edge_circulation_and_flux import ecf_pkg::*; (
  input logic        clk,
  input logic        rst,
  ecf_item_if.sink   edge_item,
  ecf_result_if.source result,
  ecf_cfg_if.sink    cfg
);

  logic        mode;
  logic        pipe_en;
  logic        s1_vld;
  side_t       s1_side;
  logic [23:0] s1_ang;
  logic        cos_vld;
  lane_t       cos_lane;
  logic        res_vld;
  res_t        res;
  res_t        out_data;
  logic        skid_full;
  logic signed [24:0] lat_sum;
  logic [24:0]        lat_mag;

  assign cfg.ready       = 1'b1;
  assign edge_item.ready = pipe_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
    end else if (cfg.valid) begin
      mode <= cfg.data;
    end
  end

  always_comb begin
    lat_sum = 25'(edge_item.lat_start) + 25'(edge_item.lat_end);
    lat_mag = lat_sum[24] ? 25'(-lat_sum) : 25'(lat_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (pipe_en) begin
      s1_vld <= edge_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_side.dx       <= 27'(edge_item.lon_end) - 27'(edge_item.lon_start);
      s1_side.dy       <= 25'(edge_item.lat_end) - 25'(edge_item.lat_start);
      s1_side.u        <= edge_item.east_component;
      s1_side.v        <= edge_item.north_component;
      s1_side.edge_neg <= edge_item.orientation_negative;
      s1_side.flux_neg <= (edge_item.edge_position[0] == 1'b0) ^
                          edge_item.orientation_negative;
      s1_side.mode     <= mode;
      s1_side.cos_neg  <= 1'b0;
      s1_ang           <= lat_mag[24:1];
    end
  end

  ecf_cosine u_cosine (
    .clk    (clk),
    .rst    (rst),
    .en     (pipe_en),
    .vld_i  (s1_vld),
    .side_i (s1_side),
    .ang_i  (s1_ang),
    .vld_o  (cos_vld),
    .lane_o (cos_lane)
  );

  ecf_combine u_combine (
    .clk    (clk),
    .rst    (rst),
    .en     (pipe_en),
    .vld_i  (cos_vld),
    .lane_i (cos_lane),
    .vld_o  (res_vld),
    .res_o  (res)
  );

  ecf_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .vld_i     (res_vld),
    .data_i    (res),
    .out_ready (result.ready),
    .en        (pipe_en),
    .out_valid (result.valid),
    .out_data  (out_data),
    .skid_full (skid_full)
  );

  assign result.edge_integral = out_data.edge_integral;
  assign result.face_flux     = out_data.face_flux;

  `ECF_ASSERT_IMP(a_skid_behind_out, skid_full, result.valid, "skid entry held with output empty")
  `ECF_ASSERT_IMP(a_cos_range, cos_vld, cos_lane.t <= Q30_ONE, "cosine magnitude above one")
  `ECF_ASSERT_NXT(a_hold_on_stall, !pipe_en, $stable(res_vld), "pipeline moved while stalled")

endmodule

// File: bench/ecf_flux_checker.sv
`timescale 1ns / 1ps
// Edge circulation and flux checker: watches the item, config and result channels,
// predicts each result and compares it field by field. Depends on ecf_pkg, ecf_channels.
module ecf_flux_checker import ecf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  ecf_item_if   item,
  ecf_result_if res,
  ecf_cfg_if    cfg,
  output int    fails,
  output int    pending,
  output int    seen
);

  typedef struct {
    logic [47:0] circ;
    logic [47:0] flux;
  } flux_pair_t;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned DIVS [6] = '{132, 90, 56, 30, 12, 2};
  localparam longint SAT_HI = 64'sd140737488355327;
  localparam longint SAT_LO = -64'sd140737488355328;

  flux_pair_t awaited [$];
  logic       degree_mode;

  function automatic longint round_down_shift(longint s, int k);
    longint unsigned mag;
    mag = (s < 0) ? longint'(-s) : s;
    mag = (mag + (64'd1 << (k - 1))) >> k;
    return (s < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clip48(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint cos_of_mean(longint lat_sum);
    longint unsigned a, x, y, t, p;
    bit neg;
    neg = 0;
    a = (lat_sum < 0) ? longint'(-lat_sum) : lat_sum;
    a = a >> 1;
    a = a % (64'd360 << FRAC_BITS);
    if (a > (64'd180 << FRAC_BITS)) a = (64'd360 << FRAC_BITS) - a;
    if (a > (64'd90 << FRAC_BITS)) begin
      a = (64'd180 << FRAC_BITS) - a;
      neg = 1;
    end
    x = (a * 64'd74961321) >> (FRAC_BITS + 2);
    y = (x * x) >> 30;
    t = ONE_Q30;
    for (int i = 0; i < 6; i++) begin
      p = ((y * t) >> 30) / DIVS[i];
      t = (p > ONE_Q30) ? 0 : ONE_Q30 - p;
    end
    return neg ? -longint'(t) : longint'(t);
  endfunction

  function automatic flux_pair_t predict_edge(logic mode);
    longint lon0, lat0, lon1, lat1, u, v, dx, dy, cdx, circ, flux;
    flux_pair_t r;
    lon0 = item.lon_start;
    lat0 = item.lat_start;
    lon1 = item.lon_end;
    lat1 = item.lat_end;
    u = item.east_component;
    v = item.north_component;
    dx = lon1 - lon0;
    dy = lat1 - lat0;
    cdx = mode ? round_down_shift(cos_of_mean(lat0 + lat1) * dx, 30) : dx;
    circ = round_down_shift(u * cdx + v * dy, FRAC_BITS);
    flux = round_down_shift(u * dy - v * cdx, FRAC_BITS);
    if (item.orientation_negative) circ = -circ;
    if ((item.edge_position[0] == 1'b0) != item.orientation_negative) flux = -flux;
    r.circ = clip48(circ);
    r.flux = clip48(flux);
    return r;
  endfunction

  task automatic report(string what, logic [47:0] got, logic [47:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what,
             $signed(got), $signed(want));
    fails++;
  endtask

  initial begin
    fails = 0;
    seen = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      awaited.delete();
      degree_mode = 1'b1;
    end else begin
      if (cfg.valid && cfg.ready) degree_mode = cfg.data;
      if (item.valid && item.ready) awaited.push_back(predict_edge(degree_mode));
      if (res.valid && res.ready) begin
        seen++;
        if (awaited.size() == 0) begin
          $display("%0t: result transaction with nothing outstanding", $time);
          fails++;
        end else begin
          flux_pair_t e;
          e = awaited.pop_front();
          if (res.edge_integral !== e.circ) report("edge_integral", res.edge_integral, e.circ);
          if (res.face_flux !== e.flux) report("face_flux", res.face_flux, e.flux);
        end
      end
    end
    pending = awaited.size();
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for edge_circulation_and_flux: drives edges and mode writes,
// stalls the result side and gives the verdict. Depends on ecf_pkg, ecf_channels, ecf_flux_checker.
module tb_top;
  import ecf_pkg::*;

  localparam int LON_MAX = 23592960;
  localparam int LAT_MAX = 5898240;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails, pending, seen, items, burst_left, cyc;

  ecf_item_if   item_ch();
  ecf_result_if res_ch();
  ecf_cfg_if    cfg_ch();

  edge_circulation_and_flux i_dut (
    .clk(clk), .rst(rst), .edge_item(item_ch), .result(res_ch), .cfg(cfg_ch)
  );

  ecf_flux_checker i_checker (
    .clk(clk), .rst(rst), .item(item_ch), .res(res_ch), .cfg(cfg_ch),
    .fails(fails), .pending(pending), .seen(seen)
  );

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  // stall pattern rotates through always-ready, half-ready and quarter-ready phases
  initial begin
    res_ch.ready = 1'b0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      case ((cyc / 200) % 3)
        0: res_ch.ready = 1'b1;
        1: res_ch.ready = ($urandom_range(1) == 1);
        default: res_ch.ready = ($urandom_range(3) == 0);
      endcase
    end
  end

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic push(int lon0, int lat0, int lon1, int lat1, int u, int v, int pos, int neg);
    if (burst_left == 0) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
      burst_left = $urandom_range(30, 1);
    end
    item_ch.lon_start = 26'(lon0);
    item_ch.lat_start = 24'(lat0);
    item_ch.lon_end = 26'(lon1);
    item_ch.lat_end = 24'(lat1);
    item_ch.east_component = u;
    item_ch.north_component = v;
    item_ch.edge_position = 2'(pos);
    item_ch.orientation_negative = 1'(neg);
    item_ch.valid = 1'b1;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    items++;
    burst_left--;
  endtask

  task automatic drain();
    item_ch.valid = 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (32) @(negedge clk);
  endtask

  task automatic set_mode(logic m);
    cfg_ch.data = m;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic directed();
    push(-LON_MAX, -LAT_MAX, LON_MAX, LAT_MAX, 32'h7fffffff, 32'h80000000, 0, 0);
    push(LON_MAX, LAT_MAX, -LON_MAX, -LAT_MAX, 32'h80000000, 32'h7fffffff, 1, 1);
    push(-LON_MAX, LAT_MAX, LON_MAX, LAT_MAX, 32'h80000000, 32'h80000000, 2, 0);
    push(LON_MAX, -LAT_MAX, -LON_MAX, -LAT_MAX, 32'h7fffffff, 32'h7fffffff, 3, 1);
    push(0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 0, 1);
    push(100, 1, 200, 0, 65536, -65536, 1, 0);
    push(-100, -1, 300, 0, -65536, 65536, 2, 1);
    push(0, 60 << 16, 65536, 60 << 16, 65536, 0, 3, 0);
    push(0, 45 << 16, 65536, 45 << 16, 65536, 65536, 0, 0);
    push(0, -30 << 16, 65536, -30 << 16, 1, -1, 1, 1);
    push(0, LAT_MAX, 65536, LAT_MAX - 1, 65536, 65536, 2, 0);
    push(0, 0, 1, 0, 32'h7fffffff, 0, 3, 1);
    push(0, 0, -1, 0, 32'h80000000, 0, 0, 0);
    push(0, 0, 0, 1, 0, 32'h80000000, 1, 0);
    push(1, 3, 2, 0, 32767, -32768, 2, 1);
    push(-LON_MAX, 0, -LON_MAX, 0, 32'h12345678, 32'h87654321, 3, 0);
  endtask

  task automatic random_edges(int n);
    int lon0, lat0, lon1, lat1, u, v;
    repeat (n) begin
      lon0 = span(-LON_MAX, LON_MAX);
      lat0 = span(-LAT_MAX, LAT_MAX);
      if ($urandom_range(3) == 0) begin
        lon1 = span(-LON_MAX, LON_MAX);
        lat1 = span(-LAT_MAX, LAT_MAX);
      end else begin
        lon1 = (lon0 > LON_MAX - 65536) ? lon0 - span(0, 65536) : lon0 + span(0, 65536);
        lat1 = (lat0 > LAT_MAX - 65536) ? lat0 - span(0, 65536) : lat0 + span(0, 65536);
      end
      u = $urandom;
      v = $urandom;
      if ($urandom_range(1) == 0) begin
        u = u >>> 12;
        v = v >>> 12;
      end
      push(lon0, lat0, lon1, lat1, u, v, $urandom_range(3), $urandom_range(1));
    end
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.lon_start = '0;
    item_ch.lat_start = '0;
    item_ch.lon_end = '0;
    item_ch.lat_end = '0;
    item_ch.east_component = '0;
    item_ch.north_component = '0;
    item_ch.edge_position = '0;
    item_ch.orientation_negative = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b1;
    items = 0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    directed();
    random_edges(500);
    drain();
    set_mode(1'b0);
    directed();
    random_edges(500);
    drain();
    set_mode(1'b1);
    random_edges(500);
    drain();
    set_mode(1'b0);
    random_edges(500);
    drain();
    $display("Sent %0d edges and checked %0d results over four mode phases", items, seen);
    $display("Covered degree and plane modes, all edge positions and both orientations");
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/ecf_pkg.sv
sv/ecf_channels.sv
sv/ecf_horner_step.sv
sv/ecf_cosine.sv
sv/ecf_combine.sv
sv/ecf_skid.sv
sv/edge_circulation_and_flux.sv
bench/ecf_flux_checker.sv
bench/tb_top.sv
